// ===== hdl/rcct_pkg.sv =====
// Shared types, sizes and helper functions for the capability table.
// No dependencies; the top level and the free map import this package.
package rcct_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    // The free-slot search is split into a group level and a leaf level.
    localparam int GRP_W       = SLOT_W / 2;
    localparam int LEAF_W      = SLOT_W - GRP_W;
    localparam int GRP_N       = 1 << GRP_W;
    localparam int LEAF_N      = 1 << LEAF_W;

    localparam int CMD_W       = 3;
    localparam int INDEX_W     = 16;
    localparam int KIND_W      = 16;
    localparam int WORD_W      = 32;
    localparam int SLOT_NUM_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_INC    = 3'd2,
        CMD_DEC    = 3'd3,
        CMD_REMOVE = 3'd4
    } t_cmd;

    // Everything but the reference count, written only on allocate.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] resource;
        logic [WORD_W-1:0] rights;
        logic [WORD_W-1:0] owner;
        logic [WORD_W-1:0] epoch;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Change of one slot's occupancy.
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] slot;
        logic              used;
    } t_map_upd;

    // Lowest free slot, if any.
    typedef struct packed {
        logic              any;
        logic [SLOT_W-1:0] slot;
    } t_free_info;

    function automatic logic [GRP_W-1:0] first_grp(input logic [GRP_N-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = GRP_N - 1; i >= 0; i--) begin
            if (v[i]) r = GRP_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LEAF_W-1:0] first_leaf(input logic [LEAF_N-1:0] v);
        logic [LEAF_W-1:0] r;
        r = '0;
        for (int i = LEAF_N - 1; i >= 0; i--) begin
            if (v[i]) r = LEAF_W'(i);
        end
        return r;
    endfunction

endpackage

// ===== hdl/refcounted_capability_table.sv =====
// Top level of the reference-counted capability table: command control,
// entry and refcount RAMs, occupancy map. Depends on rcct_pkg, rcct_ram, rcct_free_map.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_cmd, i_cap_index, i_new_*
//  out     | output    | o_out_valid / i_out_stall  | o_status, o_slot_number, o_entry_*
//  cfg     | input     | i_cfg_we                   | i_cfg_wdata (current epoch)
//
// A command's accept edge issues the RAM read; its execute edge, once the output is not
// stalled, writes back and loads the output register. The registered RAM read sets this
// split. A new beat is taken the cycle after the previous result is loaded.
// Reset (synchronous, active low) frees every slot at once through the occupancy
// bitmap and clears the epoch. A stalled output holds the command in its execute cycle.
module refcounted_capability_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rcct_pkg::CMD_W-1:0]   i_cmd,
    input  logic [rcct_pkg::INDEX_W-1:0] i_cap_index,
    input  logic [rcct_pkg::KIND_W-1:0]  i_new_kind,
    input  logic [rcct_pkg::WORD_W-1:0]  i_new_resource,
    input  logic [rcct_pkg::WORD_W-1:0]  i_new_rights,
    input  logic [rcct_pkg::WORD_W-1:0]  i_new_owner,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_status,
    output logic [rcct_pkg::SLOT_NUM_W-1:0] o_slot_number,
    output logic [rcct_pkg::KIND_W-1:0]  o_entry_kind,
    output logic [rcct_pkg::WORD_W-1:0]  o_entry_resource,
    output logic [rcct_pkg::WORD_W-1:0]  o_entry_rights,
    output logic [rcct_pkg::WORD_W-1:0]  o_entry_owner,
    output logic [rcct_pkg::WORD_W-1:0]  o_entry_refcount,
    output logic [rcct_pkg::WORD_W-1:0]  o_entry_epoch,
    input  logic                         i_cfg_we,
    input  logic [rcct_pkg::WORD_W-1:0]  i_cfg_wdata
);
    import rcct_pkg::*;

    // Control and command registers.
    logic              r_exec;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_epoch;
    logic [CMD_W-1:0]  r_cmd;
    logic [SLOT_W-1:0] r_idx;
    logic              r_in_range;
    logic              r_hit_used;
    logic [KIND_W-1:0] r_new_kind;
    logic [WORD_W-1:0] r_new_resource;
    logic [WORD_W-1:0] r_new_rights;
    logic [WORD_W-1:0] r_new_owner;

    // Result registers.
    logic              r_status;
    logic [SLOT_NUM_W-1:0] r_slot_number;
    t_entry            r_out_ent;
    logic [WORD_W-1:0] r_out_rc;

    logic              in_acc;
    logic              exec_go;
    logic              query_used;
    t_free_info        free;
    t_map_upd          map_upd;
    t_entry            rd_ent;
    logic [WORD_W-1:0] rd_rc;

    logic              ent_we;
    t_entry            ent_wdata;
    logic              rc_we;
    logic [WORD_W-1:0] rc_wdata;
    logic [SLOT_W-1:0] wr_slot;
    logic              hit_valid;
    logic              epoch_ok;

    logic              n_status;
    logic [SLOT_NUM_W-1:0] n_slot_number;
    t_entry            n_out_ent;
    logic [WORD_W-1:0] n_out_rc;

    assign in_acc     = i_in_valid && !r_exec;
    assign o_in_stall = r_exec;
    assign exec_go    = r_exec && (!r_out_valid || !i_out_stall);

    rcct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (wr_slot),
        .i_wdata (ent_wdata),
        .i_re    (in_acc),
        .i_raddr (i_cap_index[SLOT_W-1:0]),
        .o_rdata (rd_ent)
    );

    rcct_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SLOTS)) u_rc_ram (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (wr_slot),
        .i_wdata (rc_wdata),
        .i_re    (in_acc),
        .i_raddr (i_cap_index[SLOT_W-1:0]),
        .o_rdata (rd_rc)
    );

    rcct_free_map u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (map_upd),
        .i_query_slot (i_cap_index[SLOT_W-1:0]),
        .o_query_used (query_used),
        .o_free       (free)
    );

    assign hit_valid = r_in_range && r_hit_used;
    assign epoch_ok  = rd_ent.epoch == r_epoch;

    always_comb begin
        ent_we             = 1'b0;
        rc_we              = 1'b0;
        wr_slot            = r_idx;
        ent_wdata.kind     = r_new_kind;
        ent_wdata.resource = r_new_resource;
        ent_wdata.rights   = r_new_rights;
        ent_wdata.owner    = r_new_owner;
        ent_wdata.epoch    = r_epoch;
        rc_wdata           = rd_rc;
        map_upd.wr         = 1'b0;
        map_upd.slot       = r_idx;
        map_upd.used       = 1'b0;
        n_status           = 1'b1;
        n_slot_number      = '0;
        n_out_ent          = '0;
        n_out_rc           = '0;
        case (r_cmd)
            CMD_ALLOC: begin
                if (free.any) begin
                    wr_slot       = free.slot;
                    ent_we        = exec_go;
                    rc_we         = exec_go;
                    rc_wdata      = WORD_W'(1);
                    // An allocate with a zero kind writes the slot but leaves it free.
                    map_upd.wr    = exec_go;
                    map_upd.slot  = free.slot;
                    map_upd.used  = r_new_kind != '0;
                    n_status      = 1'b0;
                    n_slot_number = SLOT_NUM_W'(free.slot);
                end
            end
            CMD_LOOKUP: begin
                if (hit_valid) begin
                    n_status  = 1'b0;
                    n_out_ent = rd_ent;
                    n_out_rc  = rd_rc;
                end
            end
            CMD_INC: begin
                if (hit_valid && epoch_ok) begin
                    rc_we    = exec_go;
                    rc_wdata = rd_rc + WORD_W'(1);
                    n_status = 1'b0;
                end
            end
            CMD_DEC: begin
                if (hit_valid && epoch_ok) begin
                    rc_we      = exec_go;
                    rc_wdata   = rd_rc - WORD_W'(1);
                    map_upd.wr = exec_go && (rd_rc == WORD_W'(1));
                    n_status   = 1'b0;
                end
            end
            CMD_REMOVE: begin
                if (hit_valid) begin
                    map_upd.wr = exec_go;
                    n_status   = 1'b0;
                end
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec      <= 1'b0;
            r_out_valid <= 1'b0;
            r_epoch     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_epoch <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_exec <= 1'b1;
            end else if (exec_go) begin
                r_exec <= 1'b0;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd          <= i_cmd;
            r_idx          <= i_cap_index[SLOT_W-1:0];
            r_in_range     <= 32'(i_cap_index) < TABLE_SLOTS;
            r_hit_used     <= query_used;
            r_new_kind     <= i_new_kind;
            r_new_resource <= i_new_resource;
            r_new_rights   <= i_new_rights;
            r_new_owner    <= i_new_owner;
        end
        if (exec_go) begin
            r_status      <= n_status;
            r_slot_number <= n_slot_number;
            r_out_ent     <= n_out_ent;
            r_out_rc      <= n_out_rc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_slot_number    = r_slot_number;
    assign o_entry_kind     = r_out_ent.kind;
    assign o_entry_resource = r_out_ent.resource;
    assign o_entry_rights   = r_out_ent.rights;
    assign o_entry_owner    = r_out_ent.owner;
    assign o_entry_refcount = r_out_rc;
    assign o_entry_epoch    = r_out_ent.epoch;

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_exec)
        else $error("accepted command did not enter execute");

    a_alloc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go && r_cmd == CMD_ALLOC && free.any |-> free.slot != '0)
        else $error("allocate picked slot 0");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_slot_number == '0 && o_entry_kind == '0
                                    && o_entry_refcount == '0)
        else $error("failed command carries nonzero fields");
endmodule

// ===== hdl/rcct_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while no read is issued. No dependencies.
module rcct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/rcct_free_map.sv =====
// Occupancy bitmap of the table with a two-level lowest-free-slot search.
// Depends on rcct_pkg.
module rcct_free_map (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rcct_pkg::t_map_upd       i_upd,
    input  logic [rcct_pkg::SLOT_W-1:0] i_query_slot,
    output logic                     o_query_used,
    output rcct_pkg::t_free_info     o_free
);
    import rcct_pkg::*;

    logic [TABLE_SLOTS-1:0] r_used;
    logic [GRP_N-1:0]       r_grp_free;
    logic [TABLE_SLOTS-1:0] free_vec;
    logic [GRP_N-1:0]       n_grp_free;
    logic [GRP_W-1:0]       grp;
    logic [LEAF_N-1:0]      leaf_bits;
    logic [LEAF_W-1:0]      leaf;

    // Slot 0 is never handed out, so it never counts as free.
    always_comb begin
        free_vec    = ~r_used;
        free_vec[0] = 1'b0;
        for (int g = 0; g < GRP_N; g++) begin
            n_grp_free[g] = |free_vec[g*LEAF_N +: LEAF_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_grp_free <= '1;
        end else begin
            if (i_upd.wr) begin
                r_used[i_upd.slot] <= i_upd.used;
            end
            r_grp_free <= n_grp_free;
        end
    end

    // The group summary is registered from the bitmap, so it trails each update; the controller
    // never searches in the cycle right after an update.
    always_comb begin
        grp       = first_grp(r_grp_free);
        leaf_bits = free_vec[grp*LEAF_N +: LEAF_N];
        leaf      = first_leaf(leaf_bits);
    end

    assign o_free.any   = |r_grp_free;
    assign o_free.slot  = {grp, leaf};
    assign o_query_used = r_used[i_query_slot];

    a_no_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd.wr && i_upd.used |-> i_upd.slot != '0)
        else $error("slot 0 marked used");

    a_free_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_free.any && $past(i_rst_n) && !$past(i_upd.wr) |-> !r_used[o_free.slot])
        else $error("free search picked an occupied slot");
endmodule
